// ===== hw/rtl/cds_pkg.sv =====
// cds_pkg: widths, codes, controller/datapath command types and calendar
// helpers for the calendar date stepper. No dependencies.
package cds_pkg;

  localparam int AMOUNT_BITS = 10;

  localparam int CMD_W    = 2;
  localparam int UNIT_W   = 2;
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int STATUS_W = 2;

  // Day counter holds amount * 7 and never narrower than a day of month.
  localparam int COUNT_W = ((AMOUNT_BITS + 3) > DAY_W) ? (AMOUNT_BITS + 3) : DAY_W;
  // Year sum/difference headroom.
  localparam int SUM_W = ((AMOUNT_BITS > YEAR_W) ? AMOUNT_BITS : YEAR_W) + 2;

  localparam logic [YEAR_W-1:0] MAX_YEAR = YEAR_W'(9999);
  localparam int MONTHS       = 12;
  localparam int DAYS_PER_WEEK = 7;

  // Year split into year % 100 and (year / 100) % 4: floor(y / 100) as
  // (y * 5243) >> 19, exact for every 14-bit year.
  localparam int CENT         = 100;
  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_SHIFT = 19;
  localparam int PROD_W       = YEAR_W + 13;
  localparam int QUOT_W       = 8;
  localparam int REM_W        = 7;
  localparam int CENT_W       = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_SUB  = 2'd2
  } cmd_code_t;

  typedef enum logic [UNIT_W-1:0] {
    UNIT_DAYS   = 2'd0,
    UNIT_WEEKS  = 2'd1,
    UNIT_MONTHS = 2'd2,
    UNIT_YEARS  = 2'd3
  } unit_code_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_LOAD = 2'd1,
    STAT_RANGE    = 2'd2
  } stat_code_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_SPLIT_MUL,
    S_SPLIT_REM,
    S_CHECK,
    S_WALK,
    S_DIV12,
    S_APPLY,
    S_CLAMP,
    S_COMMIT,
    S_FINISH
  } ctrl_state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_LOAD,
    DP_SPLIT_MUL,
    DP_SPLIT_REM,
    DP_WALK,
    DP_DIV12,
    DP_MONTH_APPLY,
    DP_CLAMP,
    DP_COMMIT,
    DP_RESTORE,
    DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    stat_code_t code;
  } dp_cmd_t;

  typedef struct packed {
    logic load_ok;
    logic walk_done;
    logic walk_fail;
    logic div_done;
    logic apply_fail;
  } dp_stat_t;

  function automatic logic is_leap(input logic [REM_W-1:0] rem100,
                                   input logic [CENT_W-1:0] cent,
                                   input logic [1:0] low2);
    logic res;
    if (rem100 == '0) res = (cent == '0);
    else res = (low2 == 2'b00);
    return res;
  endfunction

  // Month is 0-based; codes past December read as 31.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m) inside
      4'd1:                   len = leap ? DAY_W'(29) : DAY_W'(28);
      4'd3, 4'd5, 4'd8, 4'd10: len = DAY_W'(30);
      default:                len = DAY_W'(31);
    endcase
    return len;
  endfunction

endpackage

// ===== hw/rtl/cds_if.sv =====
// cds_if: request and response channel interfaces (valid/ready plus payload).
// Depends on cds_pkg for field widths.
interface cds_req_if import cds_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CMD_W-1:0]       command;
  logic [UNIT_W-1:0]      unit;
  logic [AMOUNT_BITS-1:0] amount;
  logic [YEAR_W-1:0]      load_year;
  logic [MONTH_W-1:0]     load_month;
  logic [DAY_W-1:0]       load_day;

  modport source (output valid, command, unit, amount, load_year, load_month, load_day,
                  input ready);
  modport sink   (input valid, command, unit, amount, load_year, load_month, load_day,
                  output ready);
endinterface

interface cds_rsp_if import cds_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [YEAR_W-1:0]   cur_year;
  logic [MONTH_W-1:0]  cur_month;
  logic [DAY_W-1:0]    cur_day;
  logic [DAY_W-1:0]    month_length;
  logic                leap_flag;
  logic [STATUS_W-1:0] status;

  modport source (output valid, cur_year, cur_month, cur_day, month_length, leap_flag,
                  status, input ready);
  modport sink   (input valid, cur_year, cur_month, cur_day, month_length, leap_flag,
                  status, output ready);
endinterface

// ===== hw/rtl/cds_ctrl.sv =====
// cds_ctrl: sequencing state machine of the date stepper; drives the
// datapath by command and owns both handshakes. Depends on cds_pkg.
module cds_ctrl import cds_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [UNIT_W-1:0] in_unit,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output dp_cmd_t           cmd,
  input  dp_stat_t          stat
);

  ctrl_state_t state, state_next;
  logic        loading, loading_next;
  logic        finish_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      loading   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      loading <= loading_next;
      if (finish_fire) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next   = state;
    loading_next = loading;
    in_ready     = 1'b0;
    finish_fire  = 1'b0;
    cmd.op       = DP_NOP;
    cmd.code     = STAT_OK;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = DP_CAPTURE;
          unique case (in_command)
            CMD_LOAD: begin
              loading_next = 1'b1;
              state_next   = S_LOAD;
            end
            CMD_ADD, CMD_SUB: begin
              loading_next = 1'b0;
              unique case (in_unit)
                UNIT_DAYS, UNIT_WEEKS: state_next = S_WALK;
                UNIT_MONTHS:           state_next = S_DIV12;
                UNIT_YEARS:            state_next = S_APPLY;
                default:               state_next = S_FINISH;
              endcase
            end
            default: state_next = S_FINISH;
          endcase
        end
      end
      S_LOAD: begin
        cmd.op     = DP_LOAD;
        state_next = S_SPLIT_MUL;
      end
      S_SPLIT_MUL: begin
        cmd.op     = DP_SPLIT_MUL;
        state_next = S_SPLIT_REM;
      end
      S_SPLIT_REM: begin
        cmd.op     = DP_SPLIT_REM;
        state_next = loading ? S_CHECK : S_CLAMP;
      end
      S_CHECK: begin
        if (stat.load_ok) begin
          cmd.op = DP_COMMIT;
        end else begin
          cmd.op   = DP_RESTORE;
          cmd.code = STAT_BAD_LOAD;
        end
        state_next = S_FINISH;
      end
      S_WALK: begin
        if (stat.walk_done) begin
          cmd.op     = DP_COMMIT;
          state_next = S_FINISH;
        end else if (stat.walk_fail) begin
          cmd.op     = DP_RESTORE;
          cmd.code   = STAT_RANGE;
          state_next = S_FINISH;
        end else begin
          cmd.op = DP_WALK;
        end
      end
      S_DIV12: begin
        if (stat.div_done) state_next = S_APPLY;
        else cmd.op = DP_DIV12;
      end
      S_APPLY: begin
        if (stat.apply_fail) begin
          cmd.op     = DP_RESTORE;
          cmd.code   = STAT_RANGE;
          state_next = S_FINISH;
        end else begin
          cmd.op     = DP_MONTH_APPLY;
          state_next = S_SPLIT_MUL;
        end
      end
      S_CLAMP: begin
        cmd.op     = DP_CLAMP;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.op     = DP_COMMIT;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          finish_fire = 1'b1;
          cmd.op      = DP_OUT;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/cds_datapath.sv =====
// cds_datapath: committed date, working date, day/month walker, year split
// and result register of the date stepper. Depends on cds_pkg.
module cds_datapath import cds_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  dp_cmd_t                cmd,
  output dp_stat_t               stat,
  input  logic [CMD_W-1:0]       in_command,
  input  logic [UNIT_W-1:0]      in_unit,
  input  logic [AMOUNT_BITS-1:0] in_amount,
  input  logic [YEAR_W-1:0]      in_load_year,
  input  logic [MONTH_W-1:0]     in_load_month,
  input  logic [DAY_W-1:0]       in_load_day,
  output logic [YEAR_W-1:0]      cur_year,
  output logic [MONTH_W-1:0]     cur_month,
  output logic [DAY_W-1:0]       cur_day,
  output logic [DAY_W-1:0]       month_length,
  output logic                   leap_flag,
  output logic [STATUS_W-1:0]    status
);

  // Committed date (month 0-based) with its year split.
  logic [YEAR_W-1:0]      year;
  logic [MONTH_W-1:0]     month;
  logic [DAY_W-1:0]       day;
  logic [REM_W-1:0]       yr_rem;
  logic [CENT_W-1:0]      yr_cent;
  // Working copy.
  logic [YEAR_W-1:0]      wyear;
  logic [MONTH_W-1:0]     wmonth;
  logic [DAY_W-1:0]       wday;
  logic [REM_W-1:0]       wrem;
  logic [CENT_W-1:0]      wcent;
  // Transaction operands.
  logic [COUNT_W-1:0]     count;
  logic [AMOUNT_BITS-1:0] years;
  logic                   sub_op;
  logic [YEAR_W-1:0]      ld_year;
  logic [MONTH_W-1:0]     ld_month;
  logic [DAY_W-1:0]       ld_day;
  logic [QUOT_W-1:0]      quot;
  stat_code_t             stat_code;

  logic                   wleap, cleap;
  logic [DAY_W-1:0]       len_cur, len_prev, rem_days;
  logic [MONTH_W-1:0]     prev_month;
  logic                   fits_add, fits_sub;
  logic [PROD_W-1:0]      prod;
  logic [MONTH_W-1:0]     cnt_m, m_new;
  logic [MONTH_W:0]       msum;
  logic                   carry, borrow;
  logic [SUM_W-1:0]       ysum, yneed;
  logic [YEAR_W-1:0]      y_new;
  logic [COUNT_W-1:0]     week_days;

  assign wleap      = is_leap(wrem, wcent, wyear[1:0]);
  assign cleap      = is_leap(yr_rem, yr_cent, year[1:0]);
  assign len_cur    = month_len(wmonth, wleap);
  assign prev_month = (wmonth == '0) ? MONTH_W'(MONTHS - 1) : wmonth - MONTH_W'(1);
  // February never sits across a year change, so the current leap bit holds.
  assign len_prev   = month_len(prev_month, wleap);
  assign rem_days   = len_cur - wday;
  assign fits_add   = (count <= COUNT_W'(rem_days));
  assign fits_sub   = (count < COUNT_W'(wday));
  assign prod       = PROD_W'(wyear) * PROD_W'(DIV100_MUL);
  assign week_days  = (COUNT_W'(in_amount) << 3) - COUNT_W'(in_amount);

  assign cnt_m  = count[MONTH_W-1:0];
  assign msum   = {1'b0, wmonth} + {1'b0, cnt_m};
  assign carry  = (msum >= (MONTH_W+1)'(MONTHS));
  assign borrow = (cnt_m > wmonth);
  assign ysum   = SUM_W'(wyear) + SUM_W'(years) + SUM_W'(carry);
  assign yneed  = SUM_W'(years) + SUM_W'(borrow);

  always_comb begin
    if (sub_op) begin
      m_new = borrow ? MONTH_W'(wmonth + MONTH_W'(MONTHS) - cnt_m) : wmonth - cnt_m;
      y_new = wyear - yneed[YEAR_W-1:0];
    end else begin
      m_new = carry ? MONTH_W'(msum - (MONTH_W+1)'(MONTHS)) : msum[MONTH_W-1:0];
      y_new = ysum[YEAR_W-1:0];
    end
  end

  always_comb begin
    stat.load_ok    = (wyear <= MAX_YEAR) && (wmonth < MONTH_W'(MONTHS)) &&
                      (wday != '0) && (wday <= len_cur);
    stat.walk_done  = (count == '0);
    stat.div_done   = (count < COUNT_W'(MONTHS));
    stat.apply_fail = sub_op ? (yneed > SUM_W'(wyear)) : (ysum > SUM_W'(MAX_YEAR));
    if (sub_op) begin
      stat.walk_fail = !fits_sub && (wmonth == '0) && (wyear == '0);
    end else begin
      stat.walk_fail = !fits_add && (wmonth == MONTH_W'(MONTHS - 1)) && (wyear == MAX_YEAR);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      year    <= '0;
      month   <= '0;
      day     <= DAY_W'(1);
      yr_rem  <= '0;
      yr_cent <= '0;
      wyear   <= '0;
      wmonth  <= '0;
      wday    <= DAY_W'(1);
      wrem    <= '0;
      wcent   <= '0;
    end else begin
      unique case (cmd.op)
        DP_CAPTURE: begin
          stat_code <= STAT_OK;
          sub_op    <= (in_command == CMD_SUB);
          ld_year   <= in_load_year;
          ld_month  <= in_load_month;
          ld_day    <= in_load_day;
          years     <= (in_unit == UNIT_YEARS) ? in_amount : '0;
          case (in_unit)
            UNIT_WEEKS:  count <= week_days;
            UNIT_YEARS:  count <= '0;
            default:     count <= COUNT_W'(in_amount);
          endcase
        end
        DP_LOAD: begin
          wyear  <= ld_year;
          wmonth <= ld_month - MONTH_W'(1);
          wday   <= ld_day;
        end
        DP_SPLIT_MUL: quot <= QUOT_W'(prod >> DIV100_SHIFT);
        DP_SPLIT_REM: begin
          wrem  <= REM_W'(wyear - YEAR_W'(quot) * YEAR_W'(CENT));
          wcent <= quot[CENT_W-1:0];
        end
        DP_WALK: begin
          if (!sub_op) begin
            if (fits_add) begin
              wday  <= wday + count[DAY_W-1:0];
              count <= '0;
            end else begin
              count <= count - COUNT_W'(rem_days) - COUNT_W'(1);
              wday  <= DAY_W'(1);
              if (wmonth == MONTH_W'(MONTHS - 1)) begin
                wmonth <= '0;
                wyear  <= wyear + YEAR_W'(1);
                if (wrem == REM_W'(CENT - 1)) begin
                  wrem  <= '0;
                  wcent <= wcent + CENT_W'(1);
                end else begin
                  wrem <= wrem + REM_W'(1);
                end
              end else begin
                wmonth <= wmonth + MONTH_W'(1);
              end
            end
          end else begin
            if (fits_sub) begin
              wday  <= wday - count[DAY_W-1:0];
              count <= '0;
            end else begin
              count  <= count - COUNT_W'(wday);
              wmonth <= prev_month;
              wday   <= len_prev;
              if (wmonth == '0) begin
                wyear <= wyear - YEAR_W'(1);
                if (wrem == '0) begin
                  wrem  <= REM_W'(CENT - 1);
                  wcent <= wcent - CENT_W'(1);
                end else begin
                  wrem <= wrem - REM_W'(1);
                end
              end
            end
          end
        end
        DP_DIV12: begin
          count <= count - COUNT_W'(MONTHS);
          years <= years + AMOUNT_BITS'(1);
        end
        DP_MONTH_APPLY: begin
          wyear  <= y_new;
          wmonth <= m_new;
        end
        DP_CLAMP: if (wday > len_cur) wday <= len_cur;
        DP_COMMIT: begin
          year    <= wyear;
          month   <= wmonth;
          day     <= wday;
          yr_rem  <= wrem;
          yr_cent <= wcent;
        end
        DP_RESTORE: begin
          wyear     <= year;
          wmonth    <= month;
          wday      <= day;
          wrem      <= yr_rem;
          wcent     <= yr_cent;
          stat_code <= cmd.code;
        end
        DP_OUT: begin
          cur_year     <= year;
          cur_month    <= month + MONTH_W'(1);
          cur_day      <= day;
          month_length <= month_len(month, cleap);
          leap_flag    <= cleap;
          status       <= stat_code;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/calendar_date_stepper_core.sv =====
// calendar_date_stepper_core: top level of the Gregorian date stepper.
// Depends on cds_pkg, cds_if (channel interfaces), cds_ctrl, cds_datapath.
//
//   channel | dir | fields                                          | transaction
//   --------+-----+-------------------------------------------------+----------------------
//   req     | in  | command unit amount load_year load_month        | valid & ready
//           |     | load_day                                        |
//   rsp     | out | cur_year cur_month cur_day month_length         | valid & ready
//           |     | leap_flag status                                |
//
// One transaction in at a time; each yields exactly one response.
// A load captures, loads, splits the year and checks the date. A day or week step walks
// the month boundaries one at a time, then adds or takes the days left after the last
// crossing; a month step first divides the amount by 12 by repeated subtraction, then
// applies the months, splits the year anew and clamps the day; a year step applies,
// splits and clamps the same way. A step that leaves the year range ends early.
// Reset (rst, synchronous) leaves 0000-01-01 stored and no response pending.
// A waiting response holds in its output register; a new request is still
// taken, and its response waits until the register is free.
module calendar_date_stepper_core import cds_pkg::*; (
  input logic      clk,
  input logic      rst,
  cds_req_if.sink  req,
  cds_rsp_if.source rsp
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Sequencer: accept requests, step through load/walk/apply phases,
  // hold the response until taken.
  cds_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_command (req.command),
    .in_unit    (req.unit),
    .in_ready   (req.ready),
    .out_ready  (rsp.ready),
    .out_valid  (rsp.valid),
    .cmd        (dp_cmd),
    .stat       (dp_stat)
  );

  // Date registers, walker and result register.
  cds_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (dp_cmd),
    .stat          (dp_stat),
    .in_command    (req.command),
    .in_unit       (req.unit),
    .in_amount     (req.amount),
    .in_load_year  (req.load_year),
    .in_load_month (req.load_month),
    .in_load_day   (req.load_day),
    .cur_year      (rsp.cur_year),
    .cur_month     (rsp.cur_month),
    .cur_day       (rsp.cur_day),
    .month_length  (rsp.month_length),
    .leap_flag     (rsp.leap_flag),
    .status        (rsp.status)
  );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking bench for calendar_date_stepper_core. It drives date loads and
// day, week, month and year steps, and checks every response against a local date model.
// Depends on cds_pkg, cds_if (cds_req_if, cds_rsp_if) and the core RTL.
module tb_top;
  import cds_pkg::*;

  // Command 3 has no package code; the core treats it as a plain readback.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int AMT_MAX       = (1 << AMOUNT_BITS) - 1;
  localparam int LAST_YEAR     = int'(MAX_YEAR);
  localparam int RANDOM_ITEMS  = 830;
  localparam int HOLD_AT       = 300;   // receiver backs off here
  localparam int PAUSE_AT      = 600;   // sender drains here
  localparam int LONG_HOLD     = 200;
  localparam int IDLE_LIMIT    = 4000;  // covers the worst walk plus the long hold
  localparam int SETTLE_CYCLES = 300;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [DAY_W-1:0]    mlen;
    logic                leap;
    logic [STATUS_W-1:0] status;
  } date_rsp_t;

  // Scoreboard: carries its own copy of the stored date (month kept 0-based),
  // predicts one response per accepted request and checks responses in order.
  class date_scoreboard;
    int        cal_year, cal_month, cal_day;
    date_rsp_t pending_dates[$];
    int        errors, checked;
    int        loads, bad_loads, steps, range_hits, readbacks;

    function void reset_date();
      cal_year  = 0;
      cal_month = 0;
      cal_day   = 1;
    endfunction

    function bit leap_year(int y);
      if (y % 400 == 0) return 1'b1;
      if (y % 100 == 0) return 1'b0;
      return (y % 4 == 0);
    endfunction

    // Month is 0-based; anything past December reads as 31.
    function int days_in_month(int y, int m);
      case (m)
        1:          return leap_year(y) ? 29 : 28;
        3, 5, 8, 10: return 30;
        default:    return 31;
      endcase
    endfunction

    // Move the stored date; keep it as it was and return 0 when the year leaves range.
    function bit step_date(bit back, unit_code_t u, int amt);
      int y, m, d, n, t, k;
      y = cal_year;
      m = cal_month;
      d = cal_day;
      case (u)
        UNIT_DAYS, UNIT_WEEKS: begin
          n = (u == UNIT_WEEKS) ? amt * DAYS_PER_WEEK : amt;
          for (int i = 0; i < n; i++) begin
            if (!back) begin
              if (d >= days_in_month(y, m)) begin
                d = 1;
                if (m == 11) begin
                  m = 0;
                  y++;
                end else m++;
              end else d++;
            end else begin
              if (d <= 1) begin
                if (m == 0) begin
                  m = 11;
                  y--;
                end else m--;
                d = days_in_month(y, m);
              end else d--;
            end
            if (y < 0 || y > LAST_YEAR) return 1'b0;
          end
        end
        UNIT_MONTHS: begin
          t = back ? m - amt : m + amt;
          if (t >= 0) begin
            y += t / 12;
            m = t % 12;
          end else begin
            k = (-t + 11) / 12;
            y -= k;
            m = t + 12 * k;
          end
          if (y < 0 || y > LAST_YEAR) return 1'b0;
          if (d > days_in_month(y, m)) d = days_in_month(y, m);
        end
        default: begin
          y = back ? y - amt : y + amt;
          if (y < 0 || y > LAST_YEAR) return 1'b0;
          if (m == 1 && d == 29 && !leap_year(y)) d = 28;
        end
      endcase
      cal_year  = y;
      cal_month = m;
      cal_day   = d;
      return 1'b1;
    endfunction

    function void note_request(logic [CMD_W-1:0] cmd, unit_code_t u,
                               logic [AMOUNT_BITS-1:0] amt, logic [YEAR_W-1:0] ly,
                               logic [MONTH_W-1:0] lm, logic [DAY_W-1:0] ld);
      date_rsp_t want;
      want.status = STAT_OK;
      case (cmd)
        CMD_LOAD: begin
          loads++;
          if (ly > LAST_YEAR || lm < 1 || lm > 12 || ld < 1 ||
              ld > days_in_month(int'(ly), int'(lm) - 1)) begin
            want.status = STAT_BAD_LOAD;
            bad_loads++;
          end else begin
            cal_year  = int'(ly);
            cal_month = int'(lm) - 1;
            cal_day   = int'(ld);
          end
        end
        CMD_ADD, CMD_SUB: begin
          steps++;
          if (!step_date(cmd == CMD_SUB, u, int'(amt))) begin
            want.status = STAT_RANGE;
            range_hits++;
          end
        end
        default: readbacks++;
      endcase
      want.year  = YEAR_W'(cal_year);
      want.month = MONTH_W'(cal_month + 1);
      want.day   = DAY_W'(cal_day);
      want.mlen  = DAY_W'(days_in_month(cal_year, cal_month));
      want.leap  = leap_year(cal_year);
      pending_dates.push_back(want);
    endfunction

    function void check_response(date_rsp_t got);
      date_rsp_t want;
      checked++;
      if (pending_dates.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("Response %0d with nothing outstanding: %0d-%0d-%0d len %0d leap %0b st %0d",
                   checked, got.year, got.month, got.day, got.mlen, got.leap, got.status);
        return;
      end
      want = pending_dates.pop_front();
      if (got.year !== want.year || got.month !== want.month || got.day !== want.day ||
          got.mlen !== want.mlen || got.leap !== want.leap || got.status !== want.status) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("Mismatch on response %0d: want %0d-%0d-%0d len %0d leap %0b st %0d",
                   checked, want.year, want.month, want.day, want.mlen, want.leap,
                   want.status);
          $display("                           got %0d-%0d-%0d len %0d leap %0b st %0d",
                   got.year, got.month, got.day, got.mlen, got.leap, got.status);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  cds_req_if req_ch ();
  cds_rsp_if rsp_ch ();

  calendar_date_stepper_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  date_scoreboard sb = new;

  int idle_cycles;
  bit rx_hold_pending;   // raised by the sender, served by the receiver
  int tx_burst_left;
  bit tx_no_gap;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Watchdog: count cycles with no transaction on either channel; end the run on a hang.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles, %0d responses outstanding",
               IDLE_LIMIT, sb.pending_dates.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one request and hold it until the core takes it. Valid stays high on exit so a
  // back-to-back request never lowers and raises it in the same step.
  task automatic send_item(logic [CMD_W-1:0] cmd, unit_code_t u, logic [AMOUNT_BITS-1:0] amt,
                           logic [YEAR_W-1:0] ly, logic [MONTH_W-1:0] lm,
                           logic [DAY_W-1:0] ld);
    int gap;
    // Mix stretches of back-to-back traffic with stretches of random gaps.
    if (tx_burst_left == 0) begin
      tx_no_gap     = ($urandom_range(0, 2) == 0);
      tx_burst_left = $urandom_range(10, 50);
    end
    tx_burst_left--;
    gap = tx_no_gap ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.command    <= cmd;
    req_ch.unit       <= u;
    req_ch.amount     <= amt;
    req_ch.load_year  <= ly;
    req_ch.load_month <= lm;
    req_ch.load_day   <= ld;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(cmd, u, amt, ly, lm, ld);
  endtask

  // Load with random step fields, which the core must ignore.
  task automatic send_load(int y, int m, int d);
    send_item(CMD_LOAD, unit_code_t'($urandom_range(0, 3)),
              AMOUNT_BITS'($urandom_range(0, AMT_MAX)), YEAR_W'(y), MONTH_W'(m), DAY_W'(d));
  endtask

  // Step with random load fields, which the core must ignore.
  task automatic send_step(logic [CMD_W-1:0] cmd, unit_code_t u, int amt);
    send_item(cmd, u, AMOUNT_BITS'(amt), YEAR_W'($urandom_range(0, 16383)),
              MONTH_W'($urandom_range(0, 15)), DAY_W'($urandom_range(0, 31)));
  endtask

  // Drop valid and hold until every predicted response has come back.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending_dates.size() != 0);
  endtask

  // Receiver: mix back-to-back stretches with random stalls before responses, serve a long
  // hold-off when asked, and check every response taken.
  initial begin
    date_rsp_t got;
    int        gap, burst_left;
    bit        no_gap;
    burst_left   = 0;
    no_gap       = 1'b0;
    rsp_ch.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (rx_hold_pending) begin
        rx_hold_pending = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (burst_left == 0) begin
          no_gap     = ($urandom_range(0, 2) == 0);
          burst_left = $urandom_range(10, 50);
        end
        burst_left--;
        gap = no_gap ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      got.year   = rsp_ch.cur_year;
      got.month  = rsp_ch.cur_month;
      got.day    = rsp_ch.cur_day;
      got.mlen   = rsp_ch.month_length;
      got.leap   = rsp_ch.leap_flag;
      got.status = rsp_ch.status;
      sb.check_response(got);
    end
  end

  // Sender and run control.
  initial begin
    int pick, sel, y, m, d, amt;
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.command    = CMD_LOAD;
    req_ch.unit       = UNIT_DAYS;
    req_ch.amount     = '0;
    req_ch.load_year  = '0;
    req_ch.load_month = '0;
    req_ch.load_day   = '0;
    rx_hold_pending   = 1'b0;
    tx_burst_left     = 0;
    tx_no_gap         = 1'b0;
    idle_cycles       = 0;
    sb.reset_date();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Read back the reset date, then probe zero amount and underflow.
    send_item(CMD_UNUSED, UNIT_YEARS, AMOUNT_BITS'(AMT_MAX), '1, '1, '1);
    send_step(CMD_ADD, UNIT_DAYS, 0);
    send_step(CMD_SUB, UNIT_DAYS, 1);
    // Leap rules: year 0 and 2000 leap, 1900 not; a year step turns 29 Feb into the 28th.
    send_load(0, 2, 29);
    send_step(CMD_ADD, UNIT_YEARS, 1);
    send_load(1900, 2, 29);
    send_load(2000, 2, 29);
    // Rejected loads: year past 9999, all ones, month 0 and 13, day 0, day past month end.
    send_load(10000, 1, 1);
    send_load(16383, 15, 31);
    send_load(2023, 0, 10);
    send_load(2023, 13, 10);
    send_load(2023, 5, 0);
    send_load(2023, 4, 31);
    // Top of the range: any forward step overflows.
    send_load(9999, 12, 31);
    send_step(CMD_ADD, UNIT_DAYS, 1);
    send_step(CMD_ADD, UNIT_MONTHS, 1);
    send_step(CMD_SUB, UNIT_WEEKS, AMT_MAX);
    // Month clamp into a leap February, then the longest month and year moves.
    send_load(2000, 1, 31);
    send_step(CMD_ADD, UNIT_MONTHS, 1);
    send_step(CMD_ADD, UNIT_MONTHS, AMT_MAX);
    send_step(CMD_SUB, UNIT_YEARS, AMT_MAX);
    send_step(CMD_ADD, UNIT_DAYS, AMT_MAX);
    send_load(0, 1, 1);
    send_step(CMD_SUB, UNIT_MONTHS, 1);
    send_item(CMD_ADD, UNIT_YEARS, AMOUNT_BITS'(AMT_MAX), '1, '1, '1);
    wait_drained();

    // Random part: mostly steps of random size, with valid loads between them; some noise.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == HOLD_AT) rx_hold_pending = 1'b1;
      if (i == PAUSE_AT) wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
        // Bias toward range ends, century years and the last day of the month.
        sel = $urandom_range(0, 7);
        if (sel == 0) y = $urandom_range(0, 3);
        else if (sel == 1) y = $urandom_range(LAST_YEAR - 3, LAST_YEAR);
        else if (sel == 2) y = 100 * $urandom_range(0, 99);
        else y = $urandom_range(0, LAST_YEAR);
        m = $urandom_range(1, 12);
        d = sb.days_in_month(y, m - 1);
        if ($urandom_range(0, 2) != 0) d = $urandom_range(1, d);
        send_load(y, m, d);
      end else if (pick < 19) begin
        send_load($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31));
      end else if (pick < 22) begin
        send_item(CMD_UNUSED, unit_code_t'($urandom_range(0, 3)),
                  AMOUNT_BITS'($urandom_range(0, AMT_MAX)), YEAR_W'($urandom_range(0, 16383)),
                  MONTH_W'($urandom_range(0, 15)), DAY_W'($urandom_range(0, 31)));
      end else begin
        // Keep most amounts small so the date wanders without leaving range.
        sel = $urandom_range(0, 9);
        if (sel < 6) amt = $urandom_range(0, 40);
        else if (sel < 9) amt = $urandom_range(0, AMT_MAX);
        else begin
          case ($urandom_range(0, 2))
            0:       amt = 0;
            1:       amt = 1;
            default: amt = AMT_MAX;
          endcase
        end
        send_step($urandom_range(0, 1) ? CMD_ADD : CMD_SUB,
                  unit_code_t'($urandom_range(0, 3)), amt);
      end
    end

    // Drain, then give a stray response time to show up.
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.errors += sb.pending_dates.size();

    $display("Covered %0d loads (%0d rejected), %0d steps (%0d out of year range), %0d readbacks",
             sb.loads, sb.bad_loads, sb.steps, sb.range_hits, sb.readbacks);
    $display("Checked %0d responses, %0d failures", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/cds_pkg.sv
hw/rtl/cds_if.sv
hw/rtl/cds_ctrl.sv
hw/rtl/cds_datapath.sv
hw/rtl/calendar_date_stepper_core.sv
bench/tb_top.sv
